>>> src/lcg_pkg.sv
// Shared types, widths and reset constants of the congruential generator.
package lcg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModW  = 31;
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned AddW  = DataW + 1;
  localparam int unsigned Steps = DataW;
  localparam int unsigned CntW  = $clog2(Steps);

  localparam logic [DataW-1:0] SeedReset       = 32'd1;
  localparam logic [ModW-1:0]  ModulusReset    = 31'h7fff_ffff;
  localparam logic [DataW-1:0] MultiplierReset = 32'd1103515245;
  localparam logic [DataW-1:0] IncrementReset  = 32'd12345;

  typedef enum logic [OpW-1:0] {
    OP_RAW   = 2'd0,
    OP_RANGE = 2'd1,
    OP_FRAC  = 2'd2
  } op_e;

  typedef enum logic [IdxW-1:0] {
    CFG_SEED       = 2'd0,
    CFG_MODULUS    = 2'd1,
    CFG_MULTIPLIER = 2'd2,
    CFG_INCREMENT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ModW-1:0]  modulus;
    logic [DataW-1:0] multiplier;
    logic [DataW-1:0] increment;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] fraction;
    logic             error;
  } res_t;

endpackage

>>> src/lcg_if.sv
// Request and result channel interfaces of the congruential generator.
interface lcg_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, operation, range_low, range_high, input ready);
  modport sink   (input valid, operation, range_low, range_high, output ready);
endinterface

interface lcg_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [31:0] fraction;
  logic               error;

  modport source (output valid, value, fraction, error, input ready);
  modport sink   (input valid, value, fraction, error, output ready);
endinterface

>>> src/lcg_addsub.sv
// Shared 33-bit adder and subtractor; the top carry bit flags a >= b on subtraction.
module lcg_addsub import lcg_pkg::*; (
  input  logic [AddW-1:0] a_i,
  input  logic [AddW-1:0] b_i,
  input  logic            sub_i,
  output logic [AddW:0]   sum_o
);

  logic [AddW-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = {1'b0, a_i} + {1'b0, b_eff} + {{AddW{1'b0}}, sub_i};

endmodule

>>> src/lcg_core.sv
// Sequencer that steps the generator and forms the read-out on the shared adder.
module lcg_core import lcg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   operation_i,
  input  logic [DataW-1:0] range_low_i,
  input  logic [DataW-1:0] range_high_i,
  input  cfg_t             cfg_i,
  input  logic             seed_ld_i,
  input  logic [DataW-1:0] seed_i,
  input  logic             take_i,
  output logic             idle_o,
  output logic             done_o,
  output res_t             res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_INC, S_ABS, S_MOD, S_EUC, S_DISP, S_RDIFF,
    S_RABSV, S_RABSD, S_RMOD, S_RSIGN, S_RADD, S_FDEC, S_FDIV, S_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] gen_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] div_q;
  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] lo_q;
  logic [DataW-1:0] hi_q;
  logic             neg_q;
  res_t             res_q;

  logic [AddW-1:0]  add_a;
  logic [AddW-1:0]  add_b;
  logic             add_sub;
  logic [AddW:0]    sum;
  logic [DataW-1:0] sum_w;
  logic             ge;
  logic [DataW-1:0] step_rem;
  logic             last;

  lcg_addsub u_addsub (
    .a_i   (add_a),
    .b_i   (add_b),
    .sub_i (add_sub),
    .sum_o (sum)
  );

  assign sum_w    = sum[DataW-1:0];
  assign ge       = sum[AddW];
  // One restoring division step: keep the difference when it did not borrow.
  assign step_rem = ge ? sum_w : add_a[DataW-1:0];
  assign last     = (cnt_q == CntW'(Steps - 1));

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      S_MUL: begin
        // Horner form: acc = 2 * acc + (bit ? state : 0), multiplier bits MSB first.
        add_a = {1'b0, rem_q[DataW-2:0], 1'b0};
        add_b = {1'b0, (quo_q[DataW-1] ? gen_q : '0)};
      end
      S_INC: begin
        add_a = {1'b0, rem_q};
        add_b = {1'b0, cfg_i.increment};
      end
      S_ABS, S_RSIGN: begin
        add_b   = {1'b0, rem_q};
        add_sub = 1'b1;
      end
      S_MOD, S_RMOD, S_FDIV: begin
        add_a   = {rem_q, quo_q[DataW-1]};
        add_b   = {1'b0, div_q};
        add_sub = 1'b1;
      end
      S_EUC: begin
        add_a   = {1'b0, div_q};
        add_b   = {1'b0, rem_q};
        add_sub = 1'b1;
      end
      S_RDIFF: begin
        add_a   = {1'b0, hi_q};
        add_b   = {1'b0, lo_q};
        add_sub = 1'b1;
      end
      S_RABSV: begin
        add_b   = {1'b0, gen_q};
        add_sub = 1'b1;
      end
      S_RABSD: begin
        add_b   = {1'b0, div_q};
        add_sub = 1'b1;
      end
      S_RADD: begin
        add_a = {1'b0, rem_q};
        add_b = {1'b0, lo_q};
      end
      S_FDEC: begin
        add_a   = {1'b0, div_q};
        add_b   = AddW'(1);
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      gen_q   <= SeedReset;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (seed_ld_i) begin
            gen_q <= seed_i;
          end
          if (start_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last) begin
            state_q <= S_INC;
          end
        end
        S_INC: begin
          cnt_q <= '0;
          if (cfg_i.modulus == '0) begin
            gen_q   <= sum_w;
            state_q <= S_DISP;
          end else begin
            state_q <= S_ABS;
          end
        end
        S_ABS: state_q <= S_MOD;
        S_MOD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last) begin
            state_q <= S_EUC;
          end
        end
        S_EUC: begin
          // A negative dividend with a nonzero remainder folds back to modulus - r.
          gen_q   <= (neg_q && rem_q != '0) ? sum_w : rem_q;
          state_q <= S_DISP;
        end
        S_DISP: begin
          unique case (op_q)
            OP_RAW:   state_q <= S_DONE;
            OP_RANGE: state_q <= S_RDIFF;
            OP_FRAC:  state_q <= (cfg_i.modulus <= ModW'(1)) ? S_DONE : S_FDEC;
            default:  state_q <= S_DONE;
          endcase
        end
        S_RDIFF: state_q <= (sum_w == '0) ? S_DONE : S_RABSV;
        S_RABSV: state_q <= S_RABSD;
        S_RABSD: begin
          cnt_q   <= '0;
          state_q <= S_RMOD;
        end
        S_RMOD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last) begin
            state_q <= S_RSIGN;
          end
        end
        S_RSIGN: state_q <= S_RADD;
        S_RADD:  state_q <= S_DONE;
        S_FDEC: begin
          cnt_q   <= '0;
          state_q <= S_FDIV;
        end
        S_FDIV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q  <= operation_i;
        lo_q  <= range_low_i;
        hi_q  <= range_high_i;
        rem_q <= '0;
        quo_q <= cfg_i.multiplier;
        res_q <= '0;
      end
      S_MUL: begin
        rem_q <= sum_w;
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
      S_INC: begin
        rem_q <= sum_w;
        neg_q <= sum_w[DataW-1];
        div_q <= {1'b0, cfg_i.modulus};
      end
      S_ABS: begin
        quo_q <= neg_q ? sum_w : rem_q;
        rem_q <= '0;
      end
      S_MOD, S_RMOD: begin
        rem_q <= step_rem;
        quo_q <= {quo_q[DataW-2:0], ge};
      end
      S_DISP: begin
        unique case (op_q)
          OP_RAW:   res_q.value <= gen_q;
          OP_RANGE: res_q.error <= 1'b0;
          OP_FRAC:  res_q.error <= (cfg_i.modulus <= ModW'(1));
          default:  res_q.error <= 1'b1;
        endcase
      end
      S_RDIFF: begin
        div_q       <= sum_w;
        res_q.error <= (sum_w == '0);
      end
      S_RABSV: begin
        neg_q <= gen_q[DataW-1];
        quo_q <= gen_q[DataW-1] ? sum_w : gen_q;
        rem_q <= '0;
      end
      S_RABSD: begin
        if (div_q[DataW-1]) begin
          div_q <= sum_w;
        end
      end
      S_RSIGN: begin
        if (neg_q) begin
          rem_q <= sum_w;
        end
      end
      S_RADD: res_q.value <= sum_w;
      S_FDEC: begin
        // The word value * 2^31 starts with value >> 1 already in the remainder.
        div_q <= sum_w;
        rem_q <= {1'b0, gen_q[DataW-1:1]};
        quo_q <= {gen_q[0], {(DataW-1){1'b0}}};
      end
      S_FDIV: begin
        rem_q <= step_rem;
        quo_q <= {quo_q[DataW-2:0], ge};
        if (last) begin
          res_q.fraction <= {quo_q[DataW-2:0], ge};
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

endmodule

>>> src/lcg_random_with_range.sv
// Top level of the linear congruential generator with ranged and fractional read-out.
//
//   channel   dir   handshake           word
//   req_i     in    valid/ready         operation, range_low, range_high
//   res_o     out   valid/ready         value, fraction, error
//   cfg       in    cfg_we_i            cfg_idx_i selects, cfg_wdata_i holds data
//
// A request runs through the bit-serial multiply and divide loops on the one shared adder.
// With modulus zero the reduction loop is skipped.
// Reset loads the register defaults and a generator state of one; no clearing pass.
// The result register lets the next request start while a word waits on res_o.
module lcg_random_with_range import lcg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcg_req_if.sink          req_i,
  lcg_res_if.source        res_o,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [DataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic seed_ld;
  logic core_idle;
  logic core_done;
  logic take;
  res_t core_res;
  logic out_valid_q;
  res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus    <= ModulusReset;
      cfg_q.multiplier <= MultiplierReset;
      cfg_q.increment  <= IncrementReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEED:       cfg_q <= cfg_q;
        CFG_MODULUS:    cfg_q.modulus    <= cfg_wdata_i[ModW-1:0];
        CFG_MULTIPLIER: cfg_q.multiplier <= cfg_wdata_i;
        CFG_INCREMENT:  cfg_q.increment  <= cfg_wdata_i;
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  assign seed_ld     = cfg_we_i && (cfg_idx_i == CFG_SEED);
  assign req_i.ready = core_idle;
  assign take        = !out_valid_q || res_o.ready;

  lcg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_i.valid && core_idle),
    .operation_i  (req_i.operation),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .cfg_i        (cfg_q),
    .seed_ld_i    (seed_ld),
    .seed_i       (cfg_wdata_i),
    .take_i       (take),
    .idle_o       (core_idle),
    .done_o       (core_done),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done && take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done && take) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.value    = out_q.value;
  assign res_o.fraction = out_q.fraction;
  assign res_o.error    = out_q.error;

endmodule
